@@ hdl/ihrc_pkg.sv @@
// Package: shared types, register indexes and defaults for the IPv4 header receive check.
`timescale 1ns / 1ps
package ihrc_pkg;

  // Parameter defaults
  localparam int HEADER_BYTES_DEFAULT    = 20;
  localparam int LOCAL_ADDRESSES_DEFAULT = 4;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_COUNT     = 3'd4;

  // Header field positions and constants
  localparam int POS_PROTOCOL     = 9;
  localparam int POS_SOURCE_FIRST = 12;
  localparam int POS_SOURCE_LAST  = 15;
  localparam int POS_DEST_FIRST   = 16;
  localparam int POS_DEST_LAST    = 19;
  localparam logic [7:0]  PROTOCOL_TCP = 8'd6;
  localparam logic [15:0] SUM_INIT     = 16'hffff;

  typedef enum logic [1:0] {
    VERDICT_CHECKSUM_ERROR = 2'd0,
    VERDICT_LOCAL_TCP      = 2'd1,
    VERDICT_LOCAL_OTHER    = 2'd2,
    VERDICT_FORWARD        = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic        first_byte;
    logic [15:0] frame_length;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [15:0] payload_length;
  } out_item_t;

  // Header summary handed from the accumulator to the classifier
  typedef struct packed {
    logic        done;
    logic        sum_ok;
    logic [31:0] source;
    logic [31:0] destination;
    logic [7:0]  protocol;
    logic [15:0] frame_length;
  } hdr_info_t;

endpackage

@@ hdl/ihrc_chan_if.sv @@
// Interface: valid/ready channel carrying one request payload.
`timescale 1ns / 1ps
interface ihrc_chan_if #(
  parameter type payload_t = ihrc_pkg::in_item_t
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/ihrc_accum.sv @@
// Module: per-byte checksum accumulation and header field capture.
`timescale 1ns / 1ps
module ihrc_accum #(
  parameter int HEADER_BYTES = ihrc_pkg::HEADER_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ihrc_pkg::in_item_t  item,
  output ihrc_pkg::hdr_info_t info
);

  localparam int POS_W = $clog2(HEADER_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(HEADER_BYTES);

  logic [15:0]      sum_acc;
  logic [POS_W-1:0] byte_pos;
  logic [7:0]       pending_high;
  logic [31:0]      cap_source;
  logic [31:0]      cap_dest;
  logic [7:0]       cap_protocol;
  logic [15:0]      cap_frame_length;

  logic [15:0]      sum_base;
  logic [POS_W-1:0] pos;
  logic             take;
  logic [15:0]      word;
  logic             add_en;
  logic [16:0]      sum_wide;
  logic [15:0]      sum_next;
  logic [31:0]      source_next;
  logic [31:0]      dest_next;
  logic [7:0]       protocol_next;
  logic [15:0]      frame_length_next;

  // Restart on a first byte, drop bytes past the header end
  always_comb begin
    pos      = item.first_byte ? '0 : byte_pos;
    sum_base = item.first_byte ? ihrc_pkg::SUM_INIT : sum_acc;
    take     = item.first_byte || (byte_pos < POS_END);
    frame_length_next = item.first_byte ? item.frame_length : cap_frame_length;
  end

  // Pair bytes into big-endian words; odd trailing byte gets a zero low byte
  always_comb begin
    if (pos[0]) begin
      word   = {pending_high, item.header_byte};
      add_en = 1'b1;
    end else begin
      word   = {item.header_byte, 8'h00};
      add_en = (pos == POS_LAST);
    end
    sum_wide = {1'b0, sum_base} + {1'b0, word};
    sum_next = add_en ? (sum_wide[15:0] + {15'd0, sum_wide[16]}) : sum_base;
  end

  // Capture protocol, source and destination
  always_comb begin
    protocol_next = cap_protocol;
    source_next   = cap_source;
    dest_next     = cap_dest;
    if (pos == POS_W'(ihrc_pkg::POS_PROTOCOL)) begin
      protocol_next = item.header_byte;
    end else if (pos >= POS_W'(ihrc_pkg::POS_SOURCE_FIRST) &&
                 pos <= POS_W'(ihrc_pkg::POS_SOURCE_LAST)) begin
      source_next = {cap_source[23:0], item.header_byte};
    end else if (pos >= POS_W'(ihrc_pkg::POS_DEST_FIRST) &&
                 pos <= POS_W'(ihrc_pkg::POS_DEST_LAST)) begin
      dest_next = {cap_dest[23:0], item.header_byte};
    end
  end

  always_comb begin
    info.done         = take && (pos == POS_LAST);
    info.sum_ok       = (sum_next == ihrc_pkg::SUM_INIT);
    info.source       = source_next;
    info.destination  = dest_next;
    info.protocol     = protocol_next;
    info.frame_length = frame_length_next;
  end

  // Advance header state on each taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc          <= ihrc_pkg::SUM_INIT;
      byte_pos         <= '0;
      pending_high     <= '0;
      cap_source       <= '0;
      cap_dest         <= '0;
      cap_protocol     <= '0;
      cap_frame_length <= '0;
    end else if (step && take) begin
      sum_acc          <= sum_next;
      byte_pos         <= pos + POS_W'(1);
      if (!pos[0]) begin
        pending_high <= item.header_byte;
      end
      cap_source       <= source_next;
      cap_dest         <= dest_next;
      cap_protocol     <= protocol_next;
      cap_frame_length <= frame_length_next;
    end
  end

endmodule

@@ hdl/ihrc_classify.sv @@
// Module: local address registers, address match and verdict generation.
`timescale 1ns / 1ps
module ihrc_classify #(
  parameter int HEADER_BYTES    = ihrc_pkg::HEADER_BYTES_DEFAULT,
  parameter int LOCAL_ADDRESSES = ihrc_pkg::LOCAL_ADDRESSES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ihrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ihrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ihrc_pkg::hdr_info_t                 info,
  output ihrc_pkg::out_item_t                 result
);

  localparam logic [15:0] HDR_LEN = 16'(HEADER_BYTES);

  logic [31:0]                    local_address [LOCAL_ADDRESSES];
  logic [ihrc_pkg::COUNT_W-1:0]   local_count;
  logic [LOCAL_ADDRESSES-1:0]     hit;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOCAL_ADDRESSES; i++) begin
        local_address[i] <= '0;
      end
      local_count <= '0;
    end else if (cfg_write) begin
      if (cfg_index == ihrc_pkg::CFG_LOCAL_COUNT) begin
        local_count <= cfg_data[ihrc_pkg::COUNT_W-1:0];
      end
      for (int i = 0; i < LOCAL_ADDRESSES; i++) begin
        if (cfg_index == ihrc_pkg::CFG_INDEX_W'(i)) begin
          local_address[i] <= cfg_data[31:0];
        end
      end
    end
  end

  // Match destination against the addresses in use
  always_comb begin
    for (int i = 0; i < LOCAL_ADDRESSES; i++) begin
      hit[i] = (local_count > ihrc_pkg::COUNT_W'(i)) &&
               (local_address[i] == info.destination);
    end
  end

  // Build the verdict and payload length
  always_comb begin
    if (!info.sum_ok) begin
      result.verdict = ihrc_pkg::VERDICT_CHECKSUM_ERROR;
    end else if (|hit) begin
      result.verdict = (info.protocol == ihrc_pkg::PROTOCOL_TCP) ?
                       ihrc_pkg::VERDICT_LOCAL_TCP : ihrc_pkg::VERDICT_LOCAL_OTHER;
    end else begin
      result.verdict = ihrc_pkg::VERDICT_FORWARD;
    end
    result.source_address      = info.source;
    result.destination_address = info.destination;
    result.protocol_number     = info.protocol;
    result.payload_length      = (info.frame_length > HDR_LEN) ?
                                 (info.frame_length - HDR_LEN) : 16'd0;
  end

endmodule

@@ hdl/ipv4_header_receive_check_top.sv @@
// Top level: IPv4 header receive check with input and result registers.
`timescale 1ns / 1ps
// Takes one header byte per clock on the header channel and, on the last
// byte of a HEADER_BYTES-byte header, delivers one result request (verdict,
// addresses, protocol, payload length) on the result channel once that byte
// has passed the input and result registers. The per-byte work is one 16-bit
// end-around-carry add plus the destination compare against the local address
// registers, done between an input register and a result register, so a byte
// is accepted in every cycle; input is held only while a finished result
// waits untaken. Configuration writes take effect on the next cycle.
module ipv4_header_receive_check_top #(
  parameter int HEADER_BYTES    = ihrc_pkg::HEADER_BYTES_DEFAULT,
  parameter int LOCAL_ADDRESSES = ihrc_pkg::LOCAL_ADDRESSES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ihrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ihrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  ihrc_chan_if.sink                         header,
  ihrc_chan_if.source                       result
);

  logic                 in_valid;
  ihrc_pkg::in_item_t   in_item;
  logic                 advance;
  logic                 in_ready;
  logic                 res_valid;
  ihrc_pkg::out_item_t  res_item;
  ihrc_pkg::hdr_info_t  info;
  ihrc_pkg::out_item_t  res_next;

  assign advance        = !res_valid || result.ready;
  assign in_ready       = !in_valid || advance;
  assign header.ready   = in_ready;
  assign result.valid   = res_valid;
  assign result.payload = res_item;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (header.valid && in_ready) || (in_valid && !advance);
    end
    if (header.valid && in_ready) begin
      in_item <= header.payload;
    end
  end

  ihrc_accum #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_accum (
    .clk  (clk),
    .rst  (rst),
    .step (in_valid && advance),
    .item (in_item),
    .info (info)
  );

  ihrc_classify #(
    .HEADER_BYTES    (HEADER_BYTES),
    .LOCAL_ADDRESSES (LOCAL_ADDRESSES)
  ) u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .info      (info),
    .result    (res_next)
  );

  // Result register: load on advance, hold while the request waits
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid && info.done;
    end
    if (advance && in_valid && info.done) begin
      res_item <= res_next;
    end
  end

endmodule
